>>> hw/rtl/blm_pkg.sv
// ----------------------------------------------------------------------------
// blm_pkg
// Shared types and constants of the battery level monitor.
// ----------------------------------------------------------------------------
package blm_pkg;

    // ring depth default
    localparam int WINDOW_DEPTH = 50;

    // field widths
    localparam int SAMPLE_W  = 14;
    localparam int TEMP_W    = 8;
    localparam int ADJ_W     = 16;
    localparam int LEVEL_W   = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // temperature compensation
    localparam int TEMP_BASE     = 20;
    localparam int TEMP_INVALID  = -127;
    localparam int OFFSET_SPAN   = 150;
    localparam int MV_PER_DEGREE = OFFSET_SPAN / TEMP_BASE;

    // register reset values
    localparam logic [CFG_W-1:0] LEVEL_ONE_RST   = 16'd3000;
    localparam logic [CFG_W-1:0] LEVEL_TWO_RST   = 16'd3400;
    localparam logic [CFG_W-1:0] LEVEL_THREE_RST = 16'd3800;
    localparam logic [CFG_W-1:0] ALARM_RST       = 16'd3000;

    // level codes
    localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_THREE = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_FOUR  = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_ONE   = 2'd0,
        CFG_LEVEL_TWO   = 2'd1,
        CFG_LEVEL_THREE = 2'd2,
        CFG_ALARM       = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DSTART,
        ST_DIV,
        ST_ADJ,
        ST_OUT
    } t_state;

endpackage

>>> hw/rtl/blm_in_if.sv
// ----------------------------------------------------------------------------
// blm_in_if
// Sample channel: one battery sample with temperature and supply flag.
// ----------------------------------------------------------------------------
interface blm_in_if;
    logic                                valid;
    logic                                ready;
    logic        [blm_pkg::SAMPLE_W-1:0] sample_mv;
    logic signed [blm_pkg::TEMP_W-1:0]   ambient_temp;
    logic                                ext_power;

    modport source (output valid, output sample_mv, output ambient_temp,
                    output ext_power, input ready);
    modport sink   (input valid, input sample_mv, input ambient_temp,
                    input ext_power, output ready);
endinterface

>>> hw/rtl/blm_out_if.sv
// ----------------------------------------------------------------------------
// blm_out_if
// Result channel: adjusted voltage, level, alarm state and used temperature.
// ----------------------------------------------------------------------------
interface blm_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [blm_pkg::ADJ_W-1:0]   adjusted_mv;
    logic        [blm_pkg::LEVEL_W-1:0] level;
    logic                               alarm_active;
    logic signed [blm_pkg::TEMP_W-1:0]  temp_used;

    modport source (output valid, output adjusted_mv, output level,
                    output alarm_active, output temp_used, input ready);
    modport sink   (input valid, input adjusted_mv, input level,
                    input alarm_active, input temp_used, output ready);
endinterface

>>> hw/rtl/blm_ram.sv
// ----------------------------------------------------------------------------
// blm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module blm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/blm_div.sv
// ----------------------------------------------------------------------------
// blm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module blm_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quo;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              ge;
    logic [DVS_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
        n_rem = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

>>> hw/rtl/battery_level_monitor_core.sv
// ----------------------------------------------------------------------------
// battery_level_monitor_core
// Windowed battery voltage average with temperature compensation, level
// grading and a low battery alarm with hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one sample (mV, temperature, external power flag) per item.
//   o_out returns one result per sample: adjusted mV, level 1..4, alarm state
//   and the temperature used after invalid substitution.
//   i_cfg_we/i_cfg_idx/i_cfg_data write the four thresholds; write only while
//   no item is in flight.
// Throughput:
//   The ring scan reads one RAM entry per cycle up to the first zero entry
//   or the end of the ring, then the divider produces one quotient bit per
//   cycle. i_in.ready is high only between items.
// Reset: thresholds return to defaults, the ring reads as all zero through
//   per-entry valid bits, write pointer and alarm are cleared. No clear pass.
// Stall: the result sits in an output register; the next item is accepted
//   while it waits, and the block stalls before its own result only if the
//   previous one has still not been taken.
// ----------------------------------------------------------------------------
module battery_level_monitor_core #(
    parameter int WINDOW_DEPTH = blm_pkg::WINDOW_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    blm_in_if.sink                         i_in,
    blm_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [blm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [blm_pkg::CFG_W-1:0]      i_cfg_data
);
    localparam int IW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SW    = blm_pkg::SAMPLE_W + CW;
    localparam int SMP_W = blm_pkg::SAMPLE_W;
    localparam int TW    = blm_pkg::TEMP_W;
    localparam int XW    = blm_pkg::ADJ_W + 1;

    // configuration
    logic [blm_pkg::CFG_W-1:0] r_thr_one;
    logic [blm_pkg::CFG_W-1:0] r_thr_two;
    logic [blm_pkg::CFG_W-1:0] r_thr_three;
    logic [blm_pkg::CFG_W-1:0] r_thr_alarm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_one   <= blm_pkg::LEVEL_ONE_RST;
            r_thr_two   <= blm_pkg::LEVEL_TWO_RST;
            r_thr_three <= blm_pkg::LEVEL_THREE_RST;
            r_thr_alarm <= blm_pkg::ALARM_RST;
        end else if (i_cfg_we) begin
            case (blm_pkg::t_cfg_reg'(i_cfg_idx))
                blm_pkg::CFG_LEVEL_ONE:   r_thr_one   <= i_cfg_data;
                blm_pkg::CFG_LEVEL_TWO:   r_thr_two   <= i_cfg_data;
                blm_pkg::CFG_LEVEL_THREE: r_thr_three <= i_cfg_data;
                blm_pkg::CFG_ALARM:       r_thr_alarm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    blm_pkg::t_state r_state, n_state;
    logic [IW-1:0]           r_widx;
    logic [WINDOW_DEPTH-1:0] r_vld;
    logic [CW-1:0]           r_raddr;
    logic [CW-1:0]           r_cnt;
    logic                    r_pend;
    logic                    r_rd_vld;
    logic                    r_alarm;
    logic                    r_out_valid;

    // payload
    logic [SW-1:0]           r_sum;
    logic [SMP_W-1:0]        r_avg;
    logic signed [TW-1:0]    r_temp;
    logic                    r_ext;
    logic signed [XW-1:0]    r_adj;
    logic signed [blm_pkg::ADJ_W-1:0]   r_out_adj;
    logic [blm_pkg::LEVEL_W-1:0]        r_out_level;
    logic signed [TW-1:0]               r_out_temp;

    logic                    in_acc;
    logic                    rd_issue;
    logic                    div_start;
    logic                    out_load;
    logic [SMP_W-1:0]        rd_data;
    logic                    rd_zero;
    logic [CW-1:0]           cnt_inc;
    logic                    scan_done;
    logic                    div_done;
    logic [SW-1:0]           div_quo;
    logic signed [TW-1:0]    temp_sub;
    logic signed [XW-1:0]    temp_diff;
    logic signed [XW-1:0]    adj_calc;
    logic [blm_pkg::LEVEL_W-1:0] level_calc;
    logic                    below_alarm;
    logic                    n_alarm;

    assign in_acc = i_in.valid && i_in.ready;

    // invalid temperature reads as the base temperature
    assign temp_sub = (i_in.ambient_temp <= TW'(blm_pkg::TEMP_INVALID)) ?
                      TW'(blm_pkg::TEMP_BASE) : i_in.ambient_temp;

    blm_ram #(
        .WIDTH (SMP_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_widx),
        .i_wdata (i_in.sample_mv),
        .i_re    (rd_issue),
        .i_raddr (r_raddr[IW-1:0]),
        .o_rdata (rd_data)
    );

    blm_div #(
        .DVD_W (SW),
        .DVS_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_cnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // scan: an entry never written reads as zero
    always_comb begin
        rd_zero   = !r_rd_vld || (rd_data == '0);
        cnt_inc   = r_cnt + CW'(1);
        scan_done = r_pend && (rd_zero || (cnt_inc == CW'(WINDOW_DEPTH)));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            blm_pkg::ST_IDLE:   if (in_acc) n_state = blm_pkg::ST_SCAN;
            blm_pkg::ST_SCAN:   if (scan_done) n_state = blm_pkg::ST_DSTART;
            blm_pkg::ST_DSTART: begin
                n_state = (r_cnt == '0) ? blm_pkg::ST_ADJ : blm_pkg::ST_DIV;
            end
            blm_pkg::ST_DIV:    if (div_done) n_state = blm_pkg::ST_ADJ;
            blm_pkg::ST_ADJ:    n_state = blm_pkg::ST_OUT;
            blm_pkg::ST_OUT:    if (out_load) n_state = blm_pkg::ST_IDLE;
            default:            n_state = blm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready = 1'b0;
        rd_issue   = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            blm_pkg::ST_IDLE:   i_in.ready = 1'b1;
            blm_pkg::ST_SCAN:   rd_issue = !scan_done && (r_raddr < CW'(WINDOW_DEPTH));
            blm_pkg::ST_DSTART: div_start = (r_cnt != '0);
            blm_pkg::ST_OUT:    out_load = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blm_pkg::ST_IDLE;
            r_widx      <= '0;
            r_vld       <= '0;
            r_raddr     <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_alarm     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend   <= rd_issue;
            r_rd_vld <= r_vld[r_raddr[IW-1:0]];
            if (in_acc) begin
                r_vld[r_widx] <= 1'b1;
                r_widx        <= (r_widx == IW'(WINDOW_DEPTH - 1)) ? '0 : r_widx + IW'(1);
                r_raddr       <= '0;
                r_cnt         <= '0;
            end
            if (rd_issue) begin
                r_raddr <= r_raddr + CW'(1);
            end
            if (r_state == blm_pkg::ST_SCAN && r_pend && !rd_zero) begin
                r_cnt <= cnt_inc;
            end
            if (out_load) begin
                r_alarm     <= n_alarm;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // offset is 7 mV per degree below the base temperature
    always_comb begin
        temp_diff = XW'(blm_pkg::TEMP_BASE) - XW'(r_temp);
        adj_calc  = $signed({{(XW - SMP_W){1'b0}}, r_avg})
                    - XW'(temp_diff * XW'(blm_pkg::MV_PER_DEGREE));
    end

    always_comb begin
        if (r_adj > $signed({1'b0, r_thr_three})) begin
            level_calc = blm_pkg::LEVEL_FOUR;
        end else if (r_adj > $signed({1'b0, r_thr_two})) begin
            level_calc = blm_pkg::LEVEL_THREE;
        end else if (r_adj > $signed({1'b0, r_thr_one})) begin
            level_calc = blm_pkg::LEVEL_TWO;
        end else begin
            level_calc = blm_pkg::LEVEL_ONE;
        end
        below_alarm = !(r_adj > $signed({1'b0, r_thr_alarm}));
        // hysteresis: external power only blocks setting
        if (!below_alarm) begin
            n_alarm = 1'b0;
        end else if (!r_ext) begin
            n_alarm = 1'b1;
        end else begin
            n_alarm = r_alarm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_temp <= temp_sub;
            r_ext  <= i_in.ext_power;
            r_sum  <= '0;
        end
        if (r_state == blm_pkg::ST_SCAN && r_pend && !rd_zero) begin
            r_sum <= r_sum + SW'(rd_data);
        end
        if (r_state == blm_pkg::ST_DSTART) begin
            r_avg <= '0;
        end else if (div_done) begin
            r_avg <= div_quo[SMP_W-1:0];
        end
        if (r_state == blm_pkg::ST_ADJ) begin
            r_adj <= adj_calc;
        end
        if (out_load) begin
            r_out_adj   <= r_adj[blm_pkg::ADJ_W-1:0];
            r_out_level <= level_calc;
            r_out_temp  <= r_temp;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.adjusted_mv  = r_out_adj;
    assign o_out.level        = r_out_level;
    assign o_out.alarm_active = r_alarm;
    assign o_out.temp_used    = r_out_temp;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("input accepted twice without finishing an item");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(WINDOW_DEPTH))
        else $error("scan count beyond ring depth");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_cnt != '0))
        else $error("divider started with zero divisor");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.level >= blm_pkg::LEVEL_ONE &&
                         o_out.level <= blm_pkg::LEVEL_FOUR))
        else $error("level out of range");

    a_widx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_widx <= IW'(WINDOW_DEPTH - 1))
        else $error("write pointer beyond ring depth");
`endif
endmodule
